FILE: hdl/demb_pkg.sv
// Shared types, constants and arithmetic helpers for the diagonal emboss filter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package demb_pkg;

   // Configuration register indexes and their widths.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
   localparam int IMAGE_WIDTH_W  = 11;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int IMAGE_WIDTH_RESET  = 1024;
   localparam int IMAGE_HEIGHT_RESET = 768;

   // Pixel and stream widths.
   localparam int PIXEL_W    = 8;
   localparam int REQ_DATA_W = 3 * PIXEL_W;
   localparam int RSP_DATA_W = PIXEL_W;

   // Emboss bias added to the diagonal difference.
   localparam logic [9:0] EMBOSS_BIAS = 10'd127;

   // Where the current item sits in the frame, as seen by the datapath.
   typedef struct packed {
      logic in_image;   // real image pixel
      logic in_line;    // column inside the image: line store is touched
      logic use_older;  // the up-left neighbor lies inside the image
      logic emit;       // the item releases a result
      logic frame_end;  // last item of the frame
   } pos_type;

   // One line store entry: gray of the row two above and of the row above.
   typedef struct packed {
      logic [PIXEL_W-1:0] above2;
      logic [PIXEL_W-1:0] above;
   } line_entry_type;

   // Gray level (r+g+b)/3, truncated. The sum is at most 765, and multiplying
   // by 683/2048 is exact over that range.
   function automatic logic [PIXEL_W-1:0] gray_of(input logic [PIXEL_W-1:0] red,
                                                  input logic [PIXEL_W-1:0] green,
                                                  input logic [PIXEL_W-1:0] blue);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = {2'b00, red} + {2'b00, green} + {2'b00, blue};
      prod = {10'd0, sum} * 20'd683;
      return prod[18:11];
   endfunction

   // Difference plus bias, clamped to 0..255.
   function automatic logic [PIXEL_W-1:0] emboss_level(input logic [PIXEL_W-1:0] cur,
                                                       input logic [PIXEL_W-1:0] older);
      logic [9:0] v;
      v = {2'b00, cur} - {2'b00, older} + EMBOSS_BIAS;
      if (v[9]) begin
         return '0;
      end else if (v[8]) begin
         return '1;
      end else begin
         return v[7:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/demb_line_store.sv
// Line store holding the gray values of the two previous rows, one entry per column.
// Depends on demb_pkg for the entry type.
`default_nettype none

module demb_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output demb_pkg::line_entry_type     rd_data,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire demb_pkg::line_entry_type wr_data
);

   demb_pkg::line_entry_type mem [DEPTH];
   demb_pkg::line_entry_type rd_data_ff;

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/demb_frame_counter.sv
// Size registers and row/column counters that locate each request in the frame.
// Depends on demb_pkg for register codes and the position struct.
`default_nettype none

module demb_frame_counter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int AW         = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [demb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [demb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                step,
   output demb_pkg::pos_type                        pos,
   output logic [AW-1:0]                            col_addr
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int CMP_W = (CW > demb_pkg::IMAGE_WIDTH_W) ? CW : demb_pkg::IMAGE_WIDTH_W;
   localparam int CMP_H = (RW > demb_pkg::IMAGE_HEIGHT_W) ? RW : demb_pkg::IMAGE_HEIGHT_W;
   localparam int WIDTH_RESET  = (demb_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : demb_pkg::IMAGE_WIDTH_RESET;
   localparam int HEIGHT_RESET = (demb_pkg::IMAGE_HEIGHT_RESET > MAX_HEIGHT) ?
                                 MAX_HEIGHT : demb_pkg::IMAGE_HEIGHT_RESET;

   logic [CW-1:0] width_ff,  width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff,    col_in;
   logic [RW-1:0] row_ff,    row_in;

   logic [demb_pkg::IMAGE_WIDTH_W-1:0]  cfg_width;
   logic [demb_pkg::IMAGE_HEIGHT_W-1:0] cfg_height;
   logic row_end;
   logic frame_end;

   // Effective sizes are worked out when written: zero acts as one, and
   // values above the maximum are clipped to it.
   always_comb begin
      cfg_width  = csr_wdata[demb_pkg::IMAGE_WIDTH_W-1:0];
      cfg_height = csr_wdata[demb_pkg::IMAGE_HEIGHT_W-1:0];
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_write) begin
         case (csr_index)
            demb_pkg::REG_IMAGE_WIDTH: begin
               if (cfg_width == '0) begin
                  width_in = CW'(1);
               end else if (CMP_W'(cfg_width) > CMP_W'(MAX_WIDTH)) begin
                  width_in = CW'(MAX_WIDTH);
               end else begin
                  width_in = CW'(cfg_width);
               end
            end
            demb_pkg::REG_IMAGE_HEIGHT: begin
               if (cfg_height == '0) begin
                  height_in = RW'(1);
               end else if (CMP_H'(cfg_height) > CMP_H'(MAX_HEIGHT)) begin
                  height_in = RW'(MAX_HEIGHT);
               end else begin
                  height_in = RW'(cfg_height);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Position flags for the item now at the input.
   always_comb begin
      row_end           = (col_ff >= width_ff);
      frame_end         = row_end && (row_ff >= height_ff);
      pos.in_image      = (row_ff < height_ff) && !row_end;
      pos.in_line       = !row_end;
      pos.use_older     = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      pos.emit          = (row_ff != '0) && (col_ff != '0);
      pos.frame_end     = frame_end;
      col_addr          = col_ff[AW-1:0];
   end

   // Counter advance: the padding column ends a row, the padding row ends the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CW'(WIDTH_RESET);
         height_ff <= RW'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/demb_emboss_core.sv
// Emboss datapath: input register, gray conversion, diagonal delay and result register.
// Depends on demb_pkg for the position struct, line entry type and arithmetic.
`default_nettype none

module demb_emboss_core #(
   parameter int AW = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_accept,
   input  wire logic [demb_pkg::REQ_DATA_W-1:0]    req_data,
   input  wire demb_pkg::pos_type                  req_pos,
   input  wire logic [AW-1:0]                      req_addr,
   output logic                                    ready,
   input  wire demb_pkg::line_entry_type           line_rd_data,
   output logic                                    line_wr_en,
   output logic [AW-1:0]                           line_wr_addr,
   output demb_pkg::line_entry_type                line_wr_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [demb_pkg::PIXEL_W-1:0]            rsp_level,
   output logic                                    rsp_last
);

   logic                                 s1_valid_ff, s1_valid_in;
   logic [demb_pkg::REQ_DATA_W-1:0]      s1_data_ff;
   demb_pkg::pos_type                    s1_pos_ff;
   logic [AW-1:0]                        s1_addr_ff;
   logic [demb_pkg::PIXEL_W-1:0]         diag0_ff, diag1_ff;
   logic                                 out_valid_ff, out_valid_in;
   logic [demb_pkg::PIXEL_W-1:0]         out_level_ff;
   logic                                 out_last_ff;

   logic                                 s1_adv;
   logic [demb_pkg::PIXEL_W-1:0]         cur;
   logic [demb_pkg::PIXEL_W-1:0]         above2;
   logic [demb_pkg::PIXEL_W-1:0]         older;

   // The stage moves on whenever the result register is free or being drained.
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign ready  = !s1_valid_ff || s1_adv;

   // Per-item arithmetic on the registered request and line store data.
   always_comb begin
      cur    = s1_pos_ff.in_image ?
               demb_pkg::gray_of(s1_data_ff[7:0], s1_data_ff[15:8], s1_data_ff[23:16]) : '0;
      above2 = s1_pos_ff.in_line ? line_rd_data.above2 : '0;
      older  = s1_pos_ff.use_older ? diag1_ff : '0;
   end

   // Line store update: the row above moves down one slot, the current gray enters.
   assign line_wr_en          = s1_adv && s1_pos_ff.in_line;
   assign line_wr_addr        = s1_addr_ff;
   assign line_wr_data.above2 = line_rd_data.above;
   assign line_wr_data.above  = cur;

   // Valid bits of both stages.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = s1_pos_ff.emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
         s1_pos_ff  <= req_pos;
         s1_addr_ff <= req_addr;
      end
   end

   // Two-column delay of the row-two-above values, and the result register.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         diag0_ff     <= above2;
         diag1_ff     <= diag0_ff;
         out_level_ff <= demb_pkg::emboss_level(cur, older);
         out_last_ff  <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_level = out_level_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/diagonal_emboss_filter.sv
// Top level of the diagonal emboss filter: stream ports, configuration port and wiring.
// Depends on demb_pkg, demb_frame_counter, demb_line_store and demb_emboss_core.
`default_nettype none

// The filter takes one RGB pixel per clock in raster order and returns one gray
// emboss level per clock unless the result stalls; the level is registered behind
// the input register. Each frame is sent as (height+1) x (width+1) requests: the
// image plus one padding column per row and one padding row. The result for position
// (r-1, c-1) leaves with request (r, c), so requests in row 0 or column 0 give no
// result, and rsp_tlast marks the result released by the final padding request. The
// rate of one request per cycle is set by the line store of MAX_WIDTH entries with
// one read and one write port: it is read when a request is accepted and written
// back when that request leaves the input register, in the same cycle as the next
// read. It needs no clearing pass after reset. Sizes are to be written through the
// csr port only while the stream is idle; the block itself does not enforce this.

module diagonal_emboss_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [demb_pkg::REQ_DATA_W-1:0]     req_tdata,  // red, green, blue
   // Result stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [demb_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // level
   output logic                                     rsp_tlast,
   // Configuration writes.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [demb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [demb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                        req_accept;
   demb_pkg::pos_type           pos;
   logic [AW-1:0]               col_addr;
   demb_pkg::line_entry_type    line_rd_data;
   logic                        line_wr_en;
   logic [AW-1:0]               line_wr_addr;
   demb_pkg::line_entry_type    line_wr_data;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   // Frame position and size registers.
   demb_frame_counter #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_frame_counter (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (req_accept),
      .pos       (pos),
      .col_addr  (col_addr)
   );

   // Gray values of the two previous rows.
   demb_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_addr),
      .rd_data (line_rd_data),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data)
   );

   // Emboss arithmetic and result register.
   demb_emboss_core #(
      .AW (AW)
   ) u_emboss_core (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_data     (req_tdata),
      .req_pos      (pos),
      .req_addr     (col_addr),
      .ready        (req_tready),
      .line_rd_data (line_rd_data),
      .line_wr_en   (line_wr_en),
      .line_wr_addr (line_wr_addr),
      .line_wr_data (line_wr_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_level    (rsp_tdata),
      .rsp_last     (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: hdl/demb_checker.sv
// Port-level checks for the diagonal emboss filter, bound to the top level.
// Depends on demb_pkg for port widths and on diagonal_emboss_filter for the bind.
`default_nettype none

module demb_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [demb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                                rsp_tlast,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready
);

   // A stalled result keeps its level and frame mark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // With the result register free or draining, the input stage always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request refused while the output can move");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // Configuration writes are never held off.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind diagonal_emboss_filter demb_checker u_demb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire
